// ===== hdl/tir_pkg.sv =====
package tir_pkg;

  // Extra fraction bits carried into every square root (radicand scaled by 4^GUARD_BITS)
  localparam int GUARD_BITS = 16;

  // Slice width of the multiplier operand handled by one cell
  localparam int CHUNK = 16;

  // Edge positions inside the input record
  localparam int IDX_P     = 0;
  localparam int IDX_Q     = 1;
  localparam int IDX_R     = 2;
  localparam int IDX_OPP_R = 3;
  localparam int IDX_OPP_Q = 4;
  localparam int IDX_OPP_P = 5;
  localparam int NUM_EDGES = 6;

endpackage

// ===== hdl/tir_in_if.sv =====
interface tir_in_if #(parameter int EDGE_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [EDGE_BITS-1:0] edge_p;
  logic [EDGE_BITS-1:0] edge_q;
  logic [EDGE_BITS-1:0] edge_r;
  logic [EDGE_BITS-1:0] edge_opp_r;
  logic [EDGE_BITS-1:0] edge_opp_q;
  logic [EDGE_BITS-1:0] edge_opp_p;

  modport source (
    output valid, edge_p, edge_q, edge_r, edge_opp_r, edge_opp_q, edge_opp_p,
    input  ready
  );
  modport sink (
    input  valid, edge_p, edge_q, edge_r, edge_opp_r, edge_opp_q, edge_opp_p,
    output ready
  );
endinterface

// ===== hdl/tir_out_if.sv =====
interface tir_out_if #(parameter int EDGE_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic [EDGE_BITS-1:0] inradius;
  logic                 degenerate;

  modport source (
    output valid, inradius, degenerate,
    input  ready
  );
  modport sink (
    input  valid, inradius, degenerate,
    output ready
  );
endinterface

// ===== hdl/tir_mul.sv =====
module tir_mul
  import tir_pkg::*;
#(
  parameter int A_W    = 34,
  parameter int B_W    = 34,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     vld_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic signed [B_W-1:0]    b_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     vld_o,
  output logic signed [A_W+B_W-1:0] p_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int NCH  = (B_W + CHUNK - 1) / CHUNK;
  localparam int BX_W = NCH * CHUNK;
  localparam int P_W  = A_W + B_W;

  logic                   vld_r  [NCH];
  logic signed [A_W-1:0]  a_r    [NCH];
  logic [BX_W-1:0]        bx_r   [NCH];
  logic signed [P_W-1:0]  acc_r  [NCH];
  logic [SIDE_W-1:0]      side_r [NCH];

  // One cell per slice of b: add a times that slice, weighted, to the running sum
  for (genvar k = 0; k < NCH; k++) begin : g_cell
    logic                   vld_in;
    logic signed [A_W-1:0]  a_in;
    logic [BX_W-1:0]        bx_in;
    logic signed [P_W-1:0]  acc_in;
    logic [SIDE_W-1:0]      side_in;
    logic signed [A_W+CHUNK:0] prod;
    logic signed [P_W-1:0]  acc_nxt;

    if (k == 0) begin : g_head
      assign vld_in  = vld_i;
      assign a_in    = a_i;
      assign bx_in   = BX_W'(b_i);
      assign acc_in  = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign a_in    = a_r[k-1];
      assign bx_in   = bx_r[k-1];
      assign acc_in  = acc_r[k-1];
      assign side_in = side_r[k-1];
    end

    // top slice carries the sign of b, the others are plain magnitudes
    if (k == NCH - 1) begin : g_msb
      assign prod = a_in * $signed(bx_in[k*CHUNK +: CHUNK]);
    end else begin : g_lsb
      assign prod = a_in * $signed({1'b0, bx_in[k*CHUNK +: CHUNK]});
    end

    assign acc_nxt = acc_in + (P_W'(prod) <<< (k * CHUNK));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]    <= a_in;
        bx_r[k]   <= bx_in;
        acc_r[k]  <= acc_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[NCH-1];
  assign p_o    = acc_r[NCH-1];
  assign side_o = side_r[NCH-1];

endmodule

// ===== hdl/tir_sqrt.sv =====
module tir_sqrt #(
  parameter int R_W    = 68,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [2*R_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [R_W-1:0]     root_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int REM_W = R_W + 2;

  logic               vld_r  [R_W];
  logic [2*R_W-1:0]   rad_r  [R_W];
  logic [REM_W-1:0]   rem_r  [R_W];
  logic [R_W-1:0]     root_r [R_W];
  logic [SIDE_W-1:0]  side_r [R_W];

  // One cell per root bit, most significant first: bring in two radicand bits,
  // try root*4+1 against the remainder
  for (genvar k = 0; k < R_W; k++) begin : g_cell
    logic               vld_in;
    logic [2*R_W-1:0]   rad_in;
    logic [REM_W-1:0]   rem_in;
    logic [R_W-1:0]     root_in;
    logic [SIDE_W-1:0]  side_in;
    logic [REM_W+1:0]   rem_ext;
    logic [REM_W+1:0]   trial;
    logic               fits;
    logic [REM_W-1:0]   rem_nxt;
    logic [R_W-1:0]     root_nxt;

    if (k == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign rem_ext  = {rem_in, rad_in[2*(R_W-1-k) +: 2]};
    assign trial    = (REM_W+2)'({root_in, 2'b01});
    assign fits     = (rem_ext >= trial);
    assign rem_nxt  = fits ? REM_W'(rem_ext - trial) : REM_W'(rem_ext);
    assign root_nxt = {root_in[R_W-2:0], fits};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[R_W-1];
  assign root_o = root_r[R_W-1];
  assign side_o = side_r[R_W-1];

endmodule

// ===== hdl/tir_div.sv =====
module tir_div #(
  parameter int N_W    = 68,
  parameter int D_W    = 70,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [N_W-1:0]     num_i,
  input  logic [D_W-1:0]     den_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [Q_W-1:0]     q_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int R_W = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;

  logic               vld_r  [Q_W];
  logic [R_W-1:0]     rem_r  [Q_W];
  logic [D_W-1:0]     den_r  [Q_W];
  logic [Q_W-1:0]     q_r    [Q_W];
  logic [SIDE_W-1:0]  side_r [Q_W];

  // One cell per quotient bit, most significant first; the numerator is below
  // den << Q_W, so Q_W restoring steps settle the quotient
  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    logic               vld_in;
    logic [R_W-1:0]     rem_in;
    logic [D_W-1:0]     den_in;
    logic [Q_W-1:0]     q_in;
    logic [SIDE_W-1:0]  side_in;
    logic [R_W-1:0]     trial;
    logic               fits;

    if (k == 0) begin : g_head
      assign vld_in  = vld_i;
      assign rem_in  = R_W'(num_i);
      assign den_in  = den_i;
      assign q_in    = '0;
      assign side_in = side_i;
    end else begin : g_body
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = R_W'(den_in) << (Q_W - 1 - k);
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? rem_in - trial : rem_in;
        den_r[k]  <= den_in;
        q_r[k]    <= {q_in[Q_W-2:0], fits};
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[Q_W-1];
  assign q_o    = q_r[Q_W-1];
  assign side_o = side_r[Q_W-1];

endmodule

// ===== hdl/tetrahedron_inradius_core.sv =====
// Channel | Dir | Handshake     | Payload
// in_ch   | in  | valid / ready | edge_p, edge_q, edge_r, edge_opp_r, edge_opp_q, edge_opp_p
// out_ch  | out | valid / ready | inradius, degenerate
//
// One item per cycle sustained while the skid register is empty; every stage of the pipeline
// takes a new item each cycle unless the pipeline holds. Each square root has NSF root bits,
// with E = EDGE_BITS and NSF = 3E + 4 + GUARD_BITS; its cell row is the longest in the pipeline.
// Synchronous active-low reset clears all valid flags; payload registers are not reset.
// A stalled result parks in a skid register; in_ch.ready drops only while it is occupied,
// and the whole pipeline holds with it.
module tetrahedron_inradius_core
  import tir_pkg::*;
#(
  parameter int EDGE_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  tir_in_if.sink   in_ch,
  tir_out_if.source out_ch
);

  localparam int E      = EDGE_BITS;
  localparam int SQ_W   = 2 * E;
  localparam int TW     = SQ_W + 2;
  localparam int HW     = 2 * TW;
  localparam int P2_W   = TW + HW;
  localparam int FW     = P2_W + 2;
  localparam int NSF    = (3 * TW + 2 * GUARD_BITS + 2) / 2;
  localparam int RAD_W  = 2 * NSF;
  localparam int SUM_W  = NSF + 2;
  localparam int DIV_W  = SUM_W + E;
  localparam int R1_N   = 9;
  localparam int R2_N   = 4;
  localparam int SQ_N   = 5;

  logic en;

  // ---------------------------------------------------------------- output side
  logic         out_vld_r, skid_vld_r;
  logic [E-1:0] out_rad_r, skid_rad_r;
  logic         out_deg_r, skid_deg_r;

  // advance the whole pipeline unless a result sits in the skid register
  assign en          = !skid_vld_r;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------- stage 0: capture
  logic         s0_vld_r;
  logic [E-1:0] s0_edge_r [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_edge_r[IDX_P]     <= in_ch.edge_p;
      s0_edge_r[IDX_Q]     <= in_ch.edge_q;
      s0_edge_r[IDX_R]     <= in_ch.edge_r;
      s0_edge_r[IDX_OPP_R] <= in_ch.edge_opp_r;
      s0_edge_r[IDX_OPP_Q] <= in_ch.edge_opp_q;
      s0_edge_r[IDX_OPP_P] <= in_ch.edge_opp_p;
    end
  end

  // ---------------------------------------------------------------- stage 1: squares
  logic            s1_vld_r;
  logic [SQ_W-1:0] s1_sq_r [NUM_EDGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        s1_sq_r[i] <= SQ_W'(s0_edge_r[i]) * SQ_W'(s0_edge_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: side sums
  logic                 s2_vld_r;
  logic signed [TW-1:0] s2_sq_r [NUM_EDGES];
  logic signed [TW-1:0] s2_t1_r, s2_t2_r, s2_t3_r, s2_d4_r;
  logic signed [TW-1:0] sqx [NUM_EDGES];

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      sqx[i] = $signed({2'b00, s1_sq_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq_r <= sqx;
      s2_t1_r <= sqx[IDX_P] + sqx[IDX_Q] - sqx[IDX_OPP_R];
      s2_t2_r <= sqx[IDX_Q] + sqx[IDX_R] - sqx[IDX_OPP_P];
      s2_t3_r <= sqx[IDX_R] + sqx[IDX_P] - sqx[IDX_OPP_Q];
      s2_d4_r <= sqx[IDX_OPP_P] + sqx[IDX_OPP_Q] - sqx[IDX_OPP_R];
    end
  end

  // ---------------------------------------------------------------- round 1 products
  logic signed [TW-1:0]   r1_a [R1_N];
  logic signed [TW-1:0]   r1_b [R1_N];
  logic signed [2*TW-1:0] r1_p [R1_N];
  logic [4*TW-1:0]        r1_side, r1_side_o;
  logic                   r1_vld;

  always_comb begin
    r1_a[0] = s2_sq_r[IDX_P];     r1_b[0] = s2_sq_r[IDX_Q];
    r1_a[1] = s2_t1_r;            r1_b[1] = s2_t1_r;
    r1_a[2] = s2_t2_r;            r1_b[2] = s2_t2_r;
    r1_a[3] = s2_t3_r;            r1_b[3] = s2_t3_r;
    r1_a[4] = s2_t1_r;            r1_b[4] = s2_t2_r;
    r1_a[5] = s2_sq_r[IDX_Q];     r1_b[5] = s2_sq_r[IDX_R];
    r1_a[6] = s2_sq_r[IDX_P];     r1_b[6] = s2_sq_r[IDX_R];
    r1_a[7] = s2_sq_r[IDX_OPP_P]; r1_b[7] = s2_sq_r[IDX_OPP_Q];
    r1_a[8] = s2_d4_r;            r1_b[8] = s2_d4_r;
    r1_side = {s2_sq_r[IDX_P], s2_sq_r[IDX_Q], s2_sq_r[IDX_R], s2_t3_r};
  end

  for (genvar i = 0; i < R1_N; i++) begin : g_r1
    if (i == 0) begin : g_lead
      tir_mul #(.A_W(TW), .B_W(TW), .SIDE_W(4 * TW)) u_mul (
        .clk, .rst_n, .en,
        .vld_i(s2_vld_r), .a_i(r1_a[i]), .b_i(r1_b[i]), .side_i(r1_side),
        .vld_o(r1_vld), .p_o(r1_p[i]), .side_o(r1_side_o)
      );
    end else begin : g_lane
      tir_mul #(.A_W(TW), .B_W(TW), .SIDE_W(1)) u_mul (
        .clk, .rst_n, .en,
        .vld_i(s2_vld_r), .a_i(r1_a[i]), .b_i(r1_b[i]), .side_i(1'b0),
        .vld_o(), .p_o(r1_p[i]), .side_o()
      );
    end
  end

  // ---------------------------------------------------------------- stage 3: face terms
  // 16 A^2 = 4xy - (x+y-z)^2 for each face
  logic                 s3_vld_r;
  logic signed [HW-1:0] s3_h_r [4];
  logic signed [HW-1:0] s3_t2s_r, s3_t3s_r, s3_t12_r;
  logic signed [TW-1:0] s3_p2_r, s3_q2_r, s3_r2_r, s3_t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_h_r[0] <= (r1_p[0] <<< 2) - r1_p[1];
      s3_h_r[1] <= (r1_p[5] <<< 2) - r1_p[2];
      s3_h_r[2] <= (r1_p[6] <<< 2) - r1_p[3];
      s3_h_r[3] <= (r1_p[7] <<< 2) - r1_p[8];
      s3_t2s_r  <= r1_p[2];
      s3_t3s_r  <= r1_p[3];
      s3_t12_r  <= r1_p[4];
      s3_p2_r   <= $signed(r1_side_o[4*TW-1 -: TW]);
      s3_q2_r   <= $signed(r1_side_o[3*TW-1 -: TW]);
      s3_r2_r   <= $signed(r1_side_o[2*TW-1 -: TW]);
      s3_t3_r   <= $signed(r1_side_o[TW-1:0]);
    end
  end

  // ---------------------------------------------------------------- round 2 products
  logic signed [TW-1:0]   r2_a [R2_N];
  logic signed [HW-1:0]   r2_b [R2_N];
  logic signed [P2_W-1:0] r2_p [R2_N];
  logic [4*HW-1:0]        r2_side, r2_side_o;
  logic                   r2_vld;

  always_comb begin
    r2_a[0] = s3_r2_r; r2_b[0] = s3_h_r[0];
    r2_a[1] = s3_p2_r; r2_b[1] = s3_t2s_r;
    r2_a[2] = s3_q2_r; r2_b[2] = s3_t3s_r;
    r2_a[3] = s3_t3_r; r2_b[3] = s3_t12_r;
    r2_side = {s3_h_r[0], s3_h_r[1], s3_h_r[2], s3_h_r[3]};
  end

  for (genvar i = 0; i < R2_N; i++) begin : g_r2
    if (i == 0) begin : g_lead
      tir_mul #(.A_W(TW), .B_W(HW), .SIDE_W(4 * HW)) u_mul (
        .clk, .rst_n, .en,
        .vld_i(s3_vld_r), .a_i(r2_a[i]), .b_i(r2_b[i]), .side_i(r2_side),
        .vld_o(r2_vld), .p_o(r2_p[i]), .side_o(r2_side_o)
      );
    end else begin : g_lane
      tir_mul #(.A_W(TW), .B_W(HW), .SIDE_W(1)) u_mul (
        .clk, .rst_n, .en,
        .vld_i(s3_vld_r), .a_i(r2_a[i]), .b_i(r2_b[i]), .side_i(1'b0),
        .vld_o(), .p_o(r2_p[i]), .side_o()
      );
    end
  end

  // ---------------------------------------------------------------- stage 4: radicands
  logic signed [FW-1:0] vol_f;
  logic signed [HW-1:0] face_h [4];
  logic                 neg_any;
  logic                 s4_vld_r, s4_bad_r;
  logic [RAD_W-1:0]     s4_rad_r [SQ_N];

  always_comb begin
    vol_f = FW'(r2_p[0]) - FW'(r2_p[1]) - FW'(r2_p[2]) + FW'(r2_p[3]);
    for (int i = 0; i < 4; i++) begin
      face_h[i] = $signed(r2_side_o[(4-i)*HW-1 -: HW]);
    end
    neg_any = vol_f[FW-1] | face_h[0][HW-1] | face_h[1][HW-1] |
              face_h[2][HW-1] | face_h[3][HW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= r2_vld;
    end
  end

  // scale by 4^GUARD_BITS; drop to zero when any square would be negative
  always_ff @(posedge clk) begin
    if (en) begin
      s4_bad_r    <= neg_any;
      s4_rad_r[0] <= neg_any ? '0 : RAD_W'(vol_f[FW-2:0]) << (2 * GUARD_BITS);
      for (int i = 0; i < 4; i++) begin
        s4_rad_r[i+1] <= neg_any ? '0 : RAD_W'(face_h[i][HW-2:0]) << (2 * GUARD_BITS);
      end
    end
  end

  // ---------------------------------------------------------------- square roots
  logic [NSF-1:0] sq_root [SQ_N];
  logic           sq_vld;
  logic           sq_bad;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    if (i == 0) begin : g_lead
      tir_sqrt #(.R_W(NSF), .SIDE_W(1)) u_sqrt (
        .clk, .rst_n, .en,
        .vld_i(s4_vld_r), .rad_i(s4_rad_r[i]), .side_i(s4_bad_r),
        .vld_o(sq_vld), .root_o(sq_root[i]), .side_o(sq_bad)
      );
    end else begin : g_lane
      tir_sqrt #(.R_W(NSF), .SIDE_W(1)) u_sqrt (
        .clk, .rst_n, .en,
        .vld_i(s4_vld_r), .rad_i(s4_rad_r[i]), .side_i(1'b0),
        .vld_o(), .root_o(sq_root[i]), .side_o()
      );
    end
  end

  // ---------------------------------------------------------------- stage 5: area sum
  logic             s5_vld_r, s5_bad_r;
  logic [NSF-1:0]   s5_sf_r;
  logic [SUM_W-1:0] s5_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_bad_r <= sq_bad;
      s5_sf_r  <= sq_root[0];
      s5_sum_r <= SUM_W'(sq_root[1]) + SUM_W'(sq_root[2]) +
                  SUM_W'(sq_root[3]) + SUM_W'(sq_root[4]);
    end
  end

  // ---------------------------------------------------------------- stage 6: range check
  // the quotient fits in E bits exactly when sF < S << E
  logic             s6_vld_r, s6_bad_r;
  logic [NSF-1:0]   s6_sf_r;
  logic [SUM_W-1:0] s6_sum_r;
  logic             too_big;

  assign too_big = (DIV_W'(s5_sf_r) >= (DIV_W'(s5_sum_r) << E));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_bad_r <= s5_bad_r | (s5_sum_r == '0) | too_big;
      s6_sf_r  <= s5_sf_r;
      s6_sum_r <= s5_sum_r;
    end
  end

  // ---------------------------------------------------------------- divide
  logic         dv_vld;
  logic         dv_bad;
  logic [E-1:0] dv_q;

  tir_div #(.N_W(NSF), .D_W(SUM_W), .Q_W(E), .SIDE_W(1)) u_div (
    .clk, .rst_n, .en,
    .vld_i(s6_vld_r), .num_i(s6_sf_r), .den_i(s6_sum_r), .side_i(s6_bad_r),
    .vld_o(dv_vld), .q_o(dv_q), .side_o(dv_bad)
  );

  // ---------------------------------------------------------------- output register and skid
  logic         deliver, take;
  logic [E-1:0] res_rad;

  assign deliver = en & dv_vld;
  assign take    = out_vld_r & out_ch.ready;
  assign res_rad = dv_bad ? '0 : dv_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // drain the skid into the output once the held result transfers
      if (take) begin
        out_rad_r  <= skid_rad_r;
        out_deg_r  <= skid_deg_r;
        skid_vld_r <= 1'b0;
      end
    end else if (deliver) begin
      if (!out_vld_r || take) begin
        out_vld_r <= 1'b1;
        out_rad_r <= res_rad;
        out_deg_r <= dv_bad;
      end else begin
        skid_vld_r <= 1'b1;
        skid_rad_r <= res_rad;
        skid_deg_r <= dv_bad;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.inradius   = out_rad_r;
  assign out_ch.degenerate = out_deg_r;

endmodule

// ===== hdl/tir_chk.sv =====
module tir_chk #(
  parameter int EDGE_BITS = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [EDGE_BITS-1:0] inradius,
  input logic                 degenerate
);

  // flagged results carry a zero radius
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> inradius == '0)
    else $error("degenerate result with nonzero inradius");

  // reset empties the output stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input stalls only while a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // the skid fills only on a blocked output transfer
  a_stall_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stall without output backpressure");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(inradius) && $stable(degenerate))
    else $error("stalled result changed");

endmodule

bind tetrahedron_inradius_core tir_chk #(.EDGE_BITS(EDGE_BITS)) u_tir_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .inradius   (out_ch.inradius),
  .degenerate (out_ch.degenerate)
);
